FILE: hw/rtl/srr_pkg.sv
// srr_pkg: shared types and constants for the stream timestamp rebuilder
// used by the channel interfaces and the top level, depends on nothing

package srr_pkg;

	localparam int NUM_STREAMS_DEF = 64;

	localparam logic [19:0] US_PER_SEC = 20'd1000000;
	localparam int VIDEO_FPS = 25;
	localparam int FPS_MAX = 60;
	localparam logic [16:0] VIDEO_DUR =
		17'(1000000 / ((VIDEO_FPS > FPS_MAX) ? FPS_MAX : VIDEO_FPS));
	localparam logic [29:0] AUDIO_NUM = 30'(1000000 * 1024);
	localparam logic [19:0] RATE_MIN = 20'd11025;
	localparam logic [19:0] RATE_MAX = 20'd48000;

	// command and media codes
	localparam logic CMD_SETUP = 1'b0;
	localparam logic CMD_PACKET = 1'b1;
	localparam logic MEDIA_VIDEO = 1'b0;
	localparam logic MEDIA_AUDIO = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [5:0]  stream;
		logic        media_kind;
		logic [19:0] audio_hz;
		logic [30:0] tb_num;
		logic [30:0] tb_den;
		logic signed [47:0] pts_in;
		logic signed [47:0] dts_in;
	} in_word_t;

	typedef struct packed {
		logic [5:0]  stream_out;
		logic signed [63:0] out_pts;
		logic signed [63:0] out_dts;
		logic        jumped;
	} out_word_t;

	// per-stream entry
	typedef struct packed {
		logic [30:0] tb_num;
		logic [30:0] tb_den;
		logic [16:0] dur;
		logic signed [63:0] last_in;
		logic signed [63:0] last_out;
	} entry_t;

	// saturate a wide signed sum to 64 bits
	function automatic logic signed [63:0] sat68(input logic signed [67:0] v);
		logic signed [63:0] r;
		if (v[67:63] == 5'b00000 || v[67:63] == 5'b11111) begin
			r = v[63:0];
		end else if (v[67]) begin
			r = {1'b1, 63'd0};
		end else begin
			r = {1'b0, {63{1'b1}}};
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/srr_ifs.sv
// srr_ifs: valid/ready channel interfaces for input and result words
// depends on srr_pkg

interface srr_item_if;
	import srr_pkg::*;
	logic valid;
	logic ready;
	in_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface srr_result_if;
	import srr_pkg::*;
	logic valid;
	logic ready;
	out_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: hw/rtl/stream_timestamp_rebuilder.sv
// stream_timestamp_rebuilder: per-stream timestamp rescaling and smoothing
// depends on srr_pkg and srr_ifs
//
// Usage:
//  items   : valid/ready input; a word is taken when both are high. cmd setup
//            stores a stream's timebase and nominal duration, cmd packet
//            rebuilds pts/dts and yields one word on results.
//  results : valid/ready output, held in a register until taken.
//  Timing  : one word at a time. A video setup is written to memory as it is taken,
//            an audio setup runs the duration division, and a packet runs the
//            single shared restoring divider 99 steps for pts and again for dts,
//            each after a 16-bit-slice multiply.
//  State   : one synchronous memory of NUM_STREAMS entries with a registered read.
//  Reset   : clears control only; no clearing pass, a stream must be set up
//            before its first packet.
//  Stall   : while results is stalled the next word is still taken; a finished
//            packet waits for the result register to free.
//  Streams at or above NUM_STREAMS are taken and dropped.

module stream_timestamp_rebuilder #(
	parameter int NUM_STREAMS = srr_pkg::NUM_STREAMS_DEF
) (
	input logic clk,
	input logic arst_n,
	srr_item_if.sink items,
	srr_result_if.source results
);
	import srr_pkg::*;

	localparam int IDXW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_MUL, S_DIV, S_CALC1, S_CALC2, S_OUT
	} state_t;

	state_t state_q;
	in_word_t item_q;
	entry_t ent_q;
	entry_t rd_q;
	entry_t mem [NUM_STREAMS];

	logic mem_we;
	logic [IDXW-1:0] mem_wa;
	entry_t mem_wd;
	logic [IDXW-1:0] mem_ra;

	logic [98:0] dvd_q;
	logic [30:0] rem_q;
	logic [30:0] dsr_q;
	logic [6:0] cnt_q;
	logic [1:0] mcnt_q;
	logic [50:0] b_q;
	logic [47:0] mag_q;
	logic neg_q;
	logic pass_q;
	logic signed [63:0] pts_us_q, dts_us_q, odts_q;
	logic signed [64:0] step_q;
	logic signed [66:0] pd_q;
	logic jump_q;
	logic out_valid_q;
	out_word_t out_q;

	logic [8:0] stream_ext;
	logic in_range;
	logic accept;
	logic [19:0] sr_clamp;
	logic [31:0] trial;
	logic qbit;
	logic [30:0] rem_next;
	logic [98:0] quot;
	logic signed [63:0] q_sat;
	logic [66:0] pp;
	logic [30:0] rd_c;

	assign items.ready = (state_q == S_IDLE);
	assign accept = items.valid && items.ready;
	assign stream_ext = 9'(items.data.stream);
	assign in_range = stream_ext < 9'(NUM_STREAMS);
	assign mem_ra = stream_ext[IDXW-1:0];

	assign results.valid = out_valid_q;
	assign results.data = out_q;

	// audio sample rate clamp
	always_comb begin
		sr_clamp = items.data.audio_hz;
		if (sr_clamp < RATE_MIN) begin
			sr_clamp = RATE_MIN;
		end
		if (sr_clamp > RATE_MAX) begin
			sr_clamp = RATE_MAX;
		end
	end

	// one restoring division step
	always_comb begin
		trial = {rem_q, dvd_q[98]};
		qbit = trial >= {1'b0, dsr_q};
		rem_next = qbit ? 31'(trial - {1'b0, dsr_q}) : trial[30:0];
		quot = {dvd_q[97:0], qbit};
	end

	// signed saturation of the rescaled magnitude
	always_comb begin
		if (neg_q) begin
			if (quot[98:64] != 35'd0 || (quot[63] && quot[62:0] != 63'd0)) begin
				q_sat = {1'b1, 63'd0};
			end else begin
				q_sat = 64'(-quot[63:0]);
			end
		end else if (quot[98:63] != 36'd0) begin
			q_sat = {1'b0, {63{1'b1}}};
		end else begin
			q_sat = quot[63:0];
		end
	end

	// one 16-bit slice of the rescale product
	assign pp = 67'(mag_q[16*mcnt_q +: 16]) * 67'(b_q);
	assign rd_c = (rd_q.tb_den == 31'd0) ? 31'd1 : rd_q.tb_den;

	// per-stream memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	// memory write port: setup and finished packet
	always_comb begin
		mem_we = 1'b0;
		mem_wa = mem_ra;
		mem_wd = '0;
		if (accept && in_range && items.data.cmd == CMD_SETUP &&
				items.data.media_kind == MEDIA_VIDEO) begin
			mem_we = 1'b1;
			mem_wd.tb_num = items.data.tb_num;
			mem_wd.tb_den = items.data.tb_den;
			mem_wd.dur = VIDEO_DUR;
		end else if (state_q == S_DIV && cnt_q == 7'd98 && item_q.cmd == CMD_SETUP) begin
			mem_we = 1'b1;
			mem_wa = IDXW'(9'(item_q.stream));
			mem_wd.tb_num = item_q.tb_num;
			mem_wd.tb_den = item_q.tb_den;
			mem_wd.dur = quot[16:0];
		end else if (state_q == S_OUT && (!out_valid_q || results.ready)) begin
			mem_we = 1'b1;
			mem_wa = IDXW'(9'(item_q.stream));
			mem_wd = ent_q;
			mem_wd.last_in = dts_us_q;
			mem_wd.last_out = odts_q;
		end
	end

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			cnt_q <= '0;
			mcnt_q <= '0;
			pass_q <= 1'b0;
		end else begin
			if (out_valid_q && results.ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && in_range) begin
						item_q <= items.data;
						if (items.data.cmd == CMD_PACKET) begin
							state_q <= S_RD;
						end else if (items.data.media_kind == MEDIA_AUDIO) begin
							dvd_q <= 99'(AUDIO_NUM);
							rem_q <= '0;
							dsr_q <= 31'(sr_clamp);
							cnt_q <= '0;
							state_q <= S_DIV;
						end
					end
				end
				S_RD: begin
					ent_q <= rd_q;
					b_q <= 51'(rd_q.tb_num) * 51'(US_PER_SEC);
					dsr_q <= rd_c;
					dvd_q <= 99'(rd_c[30:1]);
					mag_q <= item_q.pts_in[47] ? 48'(-item_q.pts_in) : item_q.pts_in;
					neg_q <= item_q.pts_in[47];
					mcnt_q <= '0;
					pass_q <= 1'b0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					dvd_q <= dvd_q + (99'(pp) << {mcnt_q, 4'b0000});
					mcnt_q <= mcnt_q + 2'd1;
					if (mcnt_q == 2'd2) begin
						rem_q <= '0;
						cnt_q <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (cnt_q != 7'd98) begin
						dvd_q <= quot;
						rem_q <= rem_next;
						cnt_q <= cnt_q + 7'd1;
					end else if (item_q.cmd == CMD_SETUP) begin
						state_q <= S_IDLE;
					end else if (!pass_q) begin
						pts_us_q <= q_sat;
						dvd_q <= 99'(dsr_q[30:1]);
						mag_q <= item_q.dts_in[47] ? 48'(-item_q.dts_in)
							: item_q.dts_in;
						neg_q <= item_q.dts_in[47];
						mcnt_q <= '0;
						pass_q <= 1'b1;
						state_q <= S_MUL;
					end else begin
						dts_us_q <= q_sat;
						state_q <= S_CALC1;
					end
				end
				S_CALC1: begin
					step_q <= 65'(dts_us_q) - 65'(ent_q.last_in);
					pd_q <= 67'(pts_us_q) - 67'(dts_us_q) + 67'({ent_q.dur, 1'b0});
					state_q <= S_CALC2;
				end
				S_CALC2: begin
					jump_q <= step_q[64] ||
						(step_q > $signed(65'(20'(5 * 20'(ent_q.dur)))));
					if (step_q[64] || (step_q > $signed(65'(20'(5 * 20'(ent_q.dur))))))
					begin
						odts_q <= sat68(68'(ent_q.last_out) + 68'(ent_q.dur));
					end else begin
						odts_q <= sat68(68'(ent_q.last_out) + 68'(step_q));
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || results.ready) begin
						out_q.stream_out <= item_q.stream;
						out_q.out_dts <= odts_q;
						out_q.out_pts <= sat68(68'(odts_q) + 68'(pd_q));
						out_q.jumped <= jump_q;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// the divider never runs past its last step
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> cnt_q <= 7'd98)
		else $error("divider step count overrun");

	// a result appears only from the output stage
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside output stage");

	// no new word is taken while a packet or an audio setup is in flight
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !items.ready)
		else $error("input ready while busy");
`endif

endmodule
